// File: hw/rtl/llp_pkg.sv
package llp_pkg;

    // Field widths fixed by the record format
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MIN_ONLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MIN_MAX  = 2'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] CODE_MIN_ONLY_RST = 8'd0;
    localparam logic [BYTE_W-1:0] CODE_MIN_MAX_RST  = 8'd1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MIN_ONLY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MIN_MAX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_HDR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERLONG  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MIN,
        PH_MAX
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] min_value;
        logic [VALUE_W-1:0] max_value;
        logic [COUNT_W-1:0] byte_count;
        logic               min_above_max;
    } result_t;

endpackage

// File: hw/rtl/llp_step.sv
module llp_step import llp_pkg::*; #(
    parameter int MAX_LEB_BYTES = 5
) (
    input  phase_t                                   phase,
    input  logic                                     has_max,
    input  logic [VALUE_W-1:0]                       acc,
    input  logic [$clog2(MAX_LEB_BYTES)-1:0]         idx,
    input  logic [VALUE_W-1:0]                       saved_min,
    input  logic [COUNT_W-1:0]                       bytes_seen,
    input  logic [BYTE_W-1:0]                        data_byte,
    input  logic                                     record_start,
    input  logic [BYTE_W-1:0]                        code_min_only,
    input  logic [BYTE_W-1:0]                        code_min_max,
    output phase_t                                   phase_next,
    output logic                                     has_max_next,
    output logic [VALUE_W-1:0]                       acc_next,
    output logic [$clog2(MAX_LEB_BYTES)-1:0]         idx_next,
    output logic [VALUE_W-1:0]                       saved_min_next,
    output logic [COUNT_W-1:0]                       bytes_seen_next,
    output logic                                     res_valid,
    output result_t                                  res
);

    localparam int IW = $clog2(MAX_LEB_BYTES);
    localparam int SW = $clog2(7 * MAX_LEB_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_LEB_BYTES - 1);

    logic [SW-1:0]      shamt;
    logic [VALUE_W-1:0] acc_or;
    logic [COUNT_W-1:0] cnt_inc;
    logic               is_min_only;
    logic               is_min_max;
    logic               more;
    logic               at_last;

    // Payload group placed at 7 bits per byte index; bits beyond 31 drop out
    assign shamt   = SW'(32'(idx) * 32'd7);
    assign acc_or  = acc | (VALUE_W'(data_byte[6:0]) << shamt);
    assign cnt_inc = (bytes_seen == {COUNT_W{1'b1}}) ? bytes_seen : bytes_seen + 1'b1;

    // Min-only wins when both codes match
    assign is_min_only = (data_byte == code_min_only);
    assign is_min_max  = !is_min_only && (data_byte == code_min_max);
    assign more        = data_byte[7];
    assign at_last     = (idx == LAST_IDX);

    // Phase and flag next state
    always_comb begin
        phase_next   = phase;
        has_max_next = has_max;
        if (record_start) begin
            has_max_next = is_min_max;
            phase_next   = (is_min_only || is_min_max) ? PH_MIN : PH_IDLE;
        end else if (phase != PH_IDLE) begin
            if (more) begin
                if (at_last) begin
                    phase_next = PH_IDLE;
                end
            end else if (phase == PH_MIN && has_max) begin
                phase_next = PH_MAX;
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    // Datapath next state and result word
    always_comb begin
        acc_next        = acc;
        idx_next        = idx;
        saved_min_next  = saved_min;
        bytes_seen_next = bytes_seen;
        res_valid       = 1'b0;
        res             = '0;
        if (record_start) begin
            acc_next        = '0;
            idx_next        = '0;
            saved_min_next  = '0;
            bytes_seen_next = '0;
            if (!is_min_only && !is_min_max) begin
                res_valid = 1'b1;
                res.kind  = KIND_BAD_HDR;
            end
        end else if (phase != PH_IDLE) begin
            bytes_seen_next = cnt_inc;
            res.byte_count  = cnt_inc;
            if (more) begin
                if (at_last) begin
                    acc_next      = '0;
                    idx_next      = '0;
                    res_valid     = 1'b1;
                    res.kind      = KIND_OVERLONG;
                    res.min_value = (phase == PH_MIN) ? acc_or : saved_min;
                    res.max_value = (phase == PH_MIN) ? '0 : acc_or;
                end else begin
                    acc_next = acc_or;
                    idx_next = idx + 1'b1;
                end
            end else if (phase == PH_MIN && has_max) begin
                saved_min_next = acc_or;
                acc_next       = '0;
                idx_next       = '0;
            end else begin
                acc_next  = '0;
                idx_next  = '0;
                res_valid = 1'b1;
                if (phase == PH_MIN) begin
                    res.kind      = KIND_MIN_ONLY;
                    res.min_value = acc_or;
                end else begin
                    res.kind          = KIND_MIN_MAX;
                    res.min_value     = saved_min;
                    res.max_value     = acc_or;
                    res.min_above_max = (saved_min > acc_or);
                end
            end
        end
    end

endmodule

// File: hw/rtl/limits_record_leb128_parser.sv
// Limits record parser: one header byte (min-only or min-max, codes set
// through the configuration port) followed by one or two unsigned LEB128
// u32 values. Each byte word is decoded combinationally, so one word per
// clock is sustained; a result appears in the output register the cycle
// after the byte that completes the record, and the input stalls only
// while that register holds a word the consumer has not taken. Bad
// headers and encodings longer than MAX_LEB_BYTES bytes give error results.
// No clearing pass after reset.
module limits_record_leb128_parser import llp_pkg::*; #(
    parameter int MAX_LEB_BYTES = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // byte input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_record_start,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_record_kind,
    output logic [VALUE_W-1:0]   m_min_value,
    output logic [VALUE_W-1:0]   m_max_value,
    output logic [COUNT_W-1:0]   m_value_byte_count,
    output logic                 m_min_above_max,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    localparam int IW = $clog2(MAX_LEB_BYTES);

    logic [BYTE_W-1:0]  code_min_only_reg;
    logic [BYTE_W-1:0]  code_min_max_reg;

    phase_t             phase_reg,      phase_next;
    logic               has_max_reg,    has_max_next;
    logic [VALUE_W-1:0] acc_reg,        acc_next;
    logic [IW-1:0]      idx_reg,        idx_next;
    logic [VALUE_W-1:0] saved_min_reg,  saved_min_next;
    logic [COUNT_W-1:0] bytes_seen_reg, bytes_seen_next;

    logic               res_valid;
    result_t            res;
    result_t            out_reg;
    logic               m_valid_reg;
    logic               s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_min_only_reg <= CODE_MIN_ONLY_RST;
            code_min_max_reg  <= CODE_MIN_MAX_RST;
        end else if (cfg_valid) begin
            if (cfg_index == REG_CODE_MIN_ONLY) begin
                code_min_only_reg <= cfg_data;
            end
            if (cfg_index == REG_CODE_MIN_MAX) begin
                code_min_max_reg <= cfg_data;
            end
        end
    end

    // Per-byte decode
    llp_step #(
        .MAX_LEB_BYTES (MAX_LEB_BYTES)
    ) u_step (
        .phase           (phase_reg),
        .has_max         (has_max_reg),
        .acc             (acc_reg),
        .idx             (idx_reg),
        .saved_min       (saved_min_reg),
        .bytes_seen      (bytes_seen_reg),
        .data_byte       (s_data_byte),
        .record_start    (s_record_start),
        .code_min_only   (code_min_only_reg),
        .code_min_max    (code_min_max_reg),
        .phase_next      (phase_next),
        .has_max_next    (has_max_next),
        .acc_next        (acc_next),
        .idx_next        (idx_next),
        .saved_min_next  (saved_min_next),
        .bytes_seen_next (bytes_seen_next),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            has_max_reg    <= 1'b0;
            acc_reg        <= '0;
            idx_reg        <= '0;
            saved_min_reg  <= '0;
            bytes_seen_reg <= '0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            has_max_reg    <= has_max_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            saved_min_reg  <= saved_min_next;
            bytes_seen_reg <= bytes_seen_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_record_kind      = out_reg.kind;
    assign m_min_value        = out_reg.min_value;
    assign m_max_value        = out_reg.max_value;
    assign m_value_byte_count = out_reg.byte_count;
    assign m_min_above_max    = out_reg.min_above_max;

    // Checks
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IW'(MAX_LEB_BYTES - 1))
        else $error("byte index past encoding limit");

    a_idle_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> acc_reg == '0)
        else $error("accumulator not cleared while idle");

    a_bad_hdr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.kind == KIND_BAD_HDR |->
            out_reg.min_value == '0 && out_reg.max_value == '0 &&
            out_reg.byte_count == '0)
        else $error("bad header word carries data");

    a_flag_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.min_above_max |-> out_reg.kind == KIND_MIN_MAX)
        else $error("min above max flagged outside min-max word");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");

endmodule

// File: test/llp_record_checker.sv
`timescale 1ns / 100ps

// Watches the byte, result and configuration channels of the limits record
// parser, predicts every result word and compares it field by field.
module llp_record_checker import llp_pkg::*; #(
    parameter int MAX_LEB_BYTES = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic                 s_record_start,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [KIND_W-1:0]    m_record_kind,
    input  logic [VALUE_W-1:0]   m_min_value,
    input  logic [VALUE_W-1:0]   m_max_value,
    input  logic [COUNT_W-1:0]   m_value_byte_count,
    input  logic                 m_min_above_max,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    // Shadow of the header codes
    logic [BYTE_W-1:0] code_only;
    logic [BYTE_W-1:0] code_both;

    // Shadow of the parser state
    phase_t            rec_phase;
    bit                want_max;
    logic [VALUE_W-1:0] acc;
    int unsigned       grp;
    logic [VALUE_W-1:0] held_min;
    int unsigned       nbytes;

    result_t expected_records[$];
    result_t want;
    result_t predicted;

    initial mismatches = 0;
    initial outstanding = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 exp_val);
        mismatches++;
    endtask

    function automatic logic [COUNT_W-1:0] clipped_count();
        return (nbytes > 15) ? 4'hF : COUNT_W'(nbytes);
    endfunction

    // Advance the shadow parser by one byte word; returns 1 when a record
    // result comes out of it.
    function automatic bit decode_limits_byte(input logic [BYTE_W-1:0] b,
                                              input logic hdr,
                                              output result_t res);
        logic [63:0] part;
        res = '0;
        if (hdr) begin
            acc = '0;
            grp = 0;
            held_min = '0;
            nbytes = 0;
            // min-only code wins when both registers hold the same value
            if (b == code_only) begin
                want_max = 1'b0;
                rec_phase = PH_MIN;
                return 1'b0;
            end
            if (b == code_both) begin
                want_max = 1'b1;
                rec_phase = PH_MIN;
                return 1'b0;
            end
            want_max = 1'b0;
            rec_phase = PH_IDLE;
            res.kind = KIND_BAD_HDR;
            return 1'b1;
        end
        // stray bytes outside a record are dropped
        if (rec_phase != PH_MIN && rec_phase != PH_MAX)
            return 1'b0;

        // payload above bit 31 falls off
        part = 64'(b[6:0]) << (7 * grp);
        acc |= part[31:0];
        nbytes++;
        grp++;

        if (b[7]) begin
            if (grp >= MAX_LEB_BYTES) begin
                res.kind       = KIND_OVERLONG;
                res.min_value  = (rec_phase == PH_MIN) ? acc : held_min;
                res.max_value  = (rec_phase == PH_MIN) ? '0 : acc;
                res.byte_count = clipped_count();
                rec_phase = PH_IDLE;
                acc = '0;
                grp = 0;
                return 1'b1;
            end
            return 1'b0;
        end

        if (rec_phase == PH_MIN && want_max) begin
            held_min = acc;
            acc = '0;
            grp = 0;
            rec_phase = PH_MAX;
            return 1'b0;
        end

        if (rec_phase == PH_MIN) begin
            res.kind      = KIND_MIN_ONLY;
            res.min_value = acc;
        end else begin
            res.kind          = KIND_MIN_MAX;
            res.min_value     = held_min;
            res.max_value     = acc;
            res.min_above_max = (held_min > acc);
        end
        res.byte_count = clipped_count();
        rec_phase = PH_IDLE;
        acc = '0;
        grp = 0;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            code_only = CODE_MIN_ONLY_RST;
            code_both = CODE_MIN_MAX_RST;
            rec_phase = PH_IDLE;
            want_max  = 1'b0;
            acc       = '0;
            grp       = 0;
            held_min  = '0;
            nbytes    = 0;
            expected_records.delete();
        end else begin
            // result words first: they can only stem from earlier bytes
            if (m_valid && m_ready) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("result word with none pending", m_record_kind, 0);
                end else begin
                    want = expected_records.pop_front();
                    if (m_record_kind !== want.kind)
                        report_mismatch("record_kind", m_record_kind, want.kind);
                    if (m_min_value !== want.min_value)
                        report_mismatch("min_value", m_min_value, want.min_value);
                    if (m_max_value !== want.max_value)
                        report_mismatch("max_value", m_max_value, want.max_value);
                    if (m_value_byte_count !== want.byte_count)
                        report_mismatch("value_byte_count", m_value_byte_count,
                                        want.byte_count);
                    if (m_min_above_max !== want.min_above_max)
                        report_mismatch("min_above_max", m_min_above_max,
                                        want.min_above_max);
                end
            end

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CODE_MIN_ONLY)
                    code_only = cfg_data;
                else if (cfg_index == REG_CODE_MIN_MAX)
                    code_both = cfg_data;
            end

            if (s_valid && s_ready) begin
                if (decode_limits_byte(s_data_byte, s_record_start, predicted))
                    expected_records.push_back(predicted);
            end
        end
        outstanding <= expected_records.size();
    end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top import llp_pkg::*;;

    localparam int LEB_LIMIT   = 5;
    localparam int ITEMS_PER_SET = 222;
    localparam int SETS        = 8;
    localparam int STALL_LIMIT = 2000;

    typedef enum {LEB_PLAIN, LEB_OVERLONG, LEB_CUT} leb_shape_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte = '0;
    logic                 s_record_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [KIND_W-1:0]    m_record_kind;
    logic [VALUE_W-1:0]   m_min_value;
    logic [VALUE_W-1:0]   m_max_value;
    logic [COUNT_W-1:0]   m_value_byte_count;
    logic                 m_min_above_max;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CODE_MIN_ONLY;
    logic [BYTE_W-1:0]    cfg_data = '0;

    int mismatches;
    int outstanding;
    int fed_items = 0;
    int stall_cycles = 0;
    bit quiet = 1'b0;
    logic [BYTE_W-1:0] cur_only = CODE_MIN_ONLY_RST;
    logic [BYTE_W-1:0] cur_both = CODE_MIN_MAX_RST;

    limits_record_leb128_parser #(.MAX_LEB_BYTES(LEB_LIMIT)) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_record_start     (s_record_start),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_record_kind      (m_record_kind),
        .m_min_value        (m_min_value),
        .m_max_value        (m_max_value),
        .m_value_byte_count (m_value_byte_count),
        .m_min_above_max    (m_min_above_max),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    llp_record_checker #(.MAX_LEB_BYTES(LEB_LIMIT)) record_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_record_start     (s_record_start),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_record_kind      (m_record_kind),
        .m_min_value        (m_min_value),
        .m_max_value        (m_max_value),
        .m_value_byte_count (m_value_byte_count),
        .m_min_above_max    (m_min_above_max),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (mismatches),
        .outstanding        (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: ready stretches with occasional stall bursts
    initial begin
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // Watchdog on cycles with no word moving anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic hdr, input bit counted);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_record_start <= hdr;
        do @(posedge aclk); while (!s_ready);
        if (counted)
            fed_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] only, input logic [BYTE_W-1:0] both);
        write_reg(REG_CODE_MIN_ONLY, only);
        write_reg(REG_CODE_MIN_MAX, both);
        cfg_valid <= 1'b0;
        cur_only = only;
        cur_both = both;
    endtask

    function automatic logic [BYTE_W-1:0] unused_header();
        logic [BYTE_W-1:0] h;
        do h = BYTE_W'($urandom); while (h == cur_only || h == cur_both);
        return h;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic leb_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return LEB_OVERLONG;
        if (r < 12)
            return LEB_CUT;
        return LEB_PLAIN;
    endfunction

    // One LEB128 value: canonical or padded, too long, or cut short
    task automatic send_value(input logic [VALUE_W-1:0] v, input leb_shape_t shape);
        int ngrp;
        int len;
        logic [BYTE_W-1:0] b;
        unique case (shape)
            LEB_OVERLONG: begin
                repeat (LEB_LIMIT) send_byte({1'b1, 7'($urandom)}, 1'b0, 1'b1);
            end
            LEB_CUT: begin
                repeat ($urandom_range(1, LEB_LIMIT - 1))
                    send_byte({1'b1, 7'($urandom)}, 1'b0, 1'b1);
            end
            default: begin
                ngrp = 1;
                while (ngrp < LEB_LIMIT && (v >> (7 * ngrp)) != 0)
                    ngrp++;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(ngrp, LEB_LIMIT) : ngrp;
                for (int i = 0; i < len; i++) begin
                    b[6:0] = 7'(v >> (7 * i));
                    // junk in the bits beyond 32 of the last group
                    if (i == 4 && $urandom_range(0, 3) == 0)
                        b[6:4] = 3'($urandom);
                    b[7] = (i < len - 1);
                    send_byte(b, 1'b0, 1'b1);
                end
            end
        endcase
    endtask

    task automatic send_random_record();
        int pick;
        logic [BYTE_W-1:0] hdr;
        bit two;
        leb_shape_t shape;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            // stray bytes with no header
            repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom), 1'b0, 1'b0);
        end else if (pick < 12) begin
            send_byte(unused_header(), 1'b1, 1'b1);
        end else if (pick < 18) begin
            send_byte(BYTE_W'($urandom), 1'($urandom), 1'b1);
        end else begin
            pick = $urandom_range(0, 99);
            hdr = (pick < 45) ? cur_only : (pick < 85) ? cur_both : BYTE_W'($urandom);
            two = (hdr == cur_both) && (hdr != cur_only);
            send_byte(hdr, 1'b1, 1'b1);
            shape = pick_shape();
            send_value(pick_value(), shape);
            if (two && shape == LEB_PLAIN)
                send_value(pick_value(), pick_shape());
        end
    endtask

    // Close any open record with a bad header, then hold off until every
    // result word is back
    task automatic settle_parser();
        send_byte(unused_header(), 1'b1, 1'b1);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // {record_start, data_byte} under the reset codes
    localparam logic [8:0] DIRECTED [25] = '{
        9'h100, 9'h000,                                 // min only, zero
        9'h101, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, // min-max, top min
        9'h000,                                         // max zero, min above max
        9'h180,                                         // unknown header
        9'h055,                                         // stray byte, dropped
        9'h100, 9'h080, 9'h080, 9'h080, 9'h080, 9'h080, // overlong min
        9'h101, 9'h081,                                 // record left open
        9'h100, 9'h07F,                                 // new header restarts
        9'h101, 9'h005, 9'h0AC, 9'h002                  // min 5, max 300
    };

    initial begin
        logic [BYTE_W-1:0] set_only [SETS];
        logic [BYTE_W-1:0] set_both [SETS];
        set_only[0] = 8'hFF; set_both[0] = 8'h00;
        set_only[1] = 8'h00; set_both[1] = 8'hFF;
        set_only[2] = 8'h80; set_both[2] = 8'h7F;
        set_only[3] = 8'h42; set_both[3] = 8'h42;
        for (int i = 4; i < SETS; i++) begin
            set_only[i] = BYTE_W'($urandom);
            set_both[i] = BYTE_W'($urandom);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8], 1'b1);
        settle_parser();

        for (int k = 0; k < SETS; k++) begin
            if (k == SETS - 1)
                quiet = 1'b1;
            set_codes(set_only[k], set_both[k]);
            while (fed_items < 25 + (k + 1) * ITEMS_PER_SET)
                send_random_record();
            settle_parser();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/llp_pkg.sv
hw/rtl/llp_step.sv
hw/rtl/limits_record_leb128_parser.sv
test/llp_record_checker.sv
test/tb_top.sv
